// ----- design/imu_fifo_frame_decoder_assert.svh -----
// Assertion macros shared by the IMU FIFO frame decoder RTL.
// Needs nothing else; included by the decoder module, which checks its own logic.
`ifndef IMU_FIFO_FRAME_DECODER_ASSERT_SVH
`define IMU_FIFO_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IMU_FFD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imu_ffd assertion failed");

// Next-cycle implication.
`define IMU_FFD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imu_ffd assertion failed");

`endif

// ----- design/imu_ffd_pkg.sv -----
// Types and constants of the IMU FIFO frame decoder.
// No dependencies; used by every module of the block.
package imu_ffd_pkg;

   localparam int WORDS_PER_FRAME = 3;
   localparam logic [1:0] LAST_POS = 2'(WORDS_PER_FRAME - 1);

   // Configuration register indexes.
   localparam logic [1:0] CSR_GYRO_TAG  = 2'd0;
   localparam logic [1:0] CSR_ACCEL_TAG = 2'd1;
   localparam logic [1:0] CSR_QUAT_TAG  = 2'd2;

   localparam logic [4:0] GYRO_TAG_RESET  = 5'd1;
   localparam logic [4:0] ACCEL_TAG_RESET = 5'd2;
   localparam logic [4:0] QUAT_TAG_RESET  = 5'd19;

   // Kind flags in the seen vector.
   localparam logic [2:0] SEEN_NONE  = 3'b000;
   localparam logic [2:0] SEEN_GYRO  = 3'b001;
   localparam logic [2:0] SEEN_ACCEL = 3'b010;
   localparam logic [2:0] SEEN_QUAT  = 3'b100;
   localparam logic [2:0] SEEN_ALL   = 3'b111;

   // Frame status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNKNOWN   = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_MISSING   = 3'd3;
   localparam logic [2:0] ST_INFNAN    = 3'd4;

   localparam logic [4:0]  HALF_EXP_ONES  = 5'h1f;
   localparam logic [17:0] HALF_EXP_REBIAS = 18'h1c000;
   localparam logic [7:0]  SUBNORM_EXP_BASE = 8'd103;
   localparam logic [3:0]  HALF_MAN_BITS = 4'd10;

   typedef logic [2:0][15:0] axes_type;

   typedef struct packed {
      logic [2:0]         frame_status;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        quat_x_bits;
      logic [31:0]        quat_y_bits;
      logic [31:0]        quat_z_bits;
   } rsp_type;

endpackage

// ----- design/imu_ffd_if.sv -----
// Valid/ready channel interfaces of the IMU FIFO frame decoder.
// Independent of the package; one carries FIFO words, the other frame results.
interface imu_ffd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tag_byte;
   logic [47:0] payload;
   logic        frame_start;

   modport source (output valid, tag_byte, payload, frame_start, input ready);
   modport sink (input valid, tag_byte, payload, frame_start, output ready);
endinterface

interface imu_ffd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         frame_status;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic [31:0]        quat_x_bits;
   logic [31:0]        quat_y_bits;
   logic [31:0]        quat_z_bits;

   modport source (output valid, frame_status, gyro_x, gyro_y, gyro_z, accel_x, accel_y,
                   accel_z, quat_x_bits, quat_y_bits, quat_z_bits, input ready);
   modport sink (input valid, frame_status, gyro_x, gyro_y, gyro_z, accel_x, accel_y,
                 accel_z, quat_x_bits, quat_y_bits, quat_z_bits, output ready);
endinterface

// ----- design/imu_fifo_frame_decoder.sv -----
// A frame's result is registered (output register or skid) when its last word is taken.
// One FIFO word per cycle while the skid is empty; each frame of three words gives one result.
// The output register has a skid stage behind it, so words keep flowing while a result waits.
// Reset is synchronous and active high: frame state and both output stages clear, and the tag
// registers return to 1, 2 and 19; the axis hold registers are not reset.
module imu_fifo_frame_decoder (
   input  logic                 clock,
   input  logic                 reset,
   imu_ffd_req_if.sink          req,
   imu_ffd_rsp_if.source        rsp,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [4:0]           csr_wdata
);

   `include "imu_fifo_frame_decoder_assert.svh"

   logic [4:0] gyro_tag_ff, accel_tag_ff, quat_tag_ff;
   logic [1:0] pos_ff, pos_in, pos_base;
   logic [2:0] seen_ff, seen_in, seen_base, seen_new;
   logic [2:0] fault_ff, fault_in, fault_base, fault_new;
   imu_ffd_pkg::axes_type gyro_ff, accel_ff, quat_ff;
   imu_ffd_pkg::axes_type gyro_in, accel_in, quat_in, word_axes;
   imu_ffd_pkg::rsp_type out_ff, skid_ff, rsp_new;
   logic out_valid_ff, skid_valid_ff;

   logic       fire, last, take, new_rsp, hold_wr;
   logic [4:0] tag;
   logic [2:0] kind, status;
   logic [31:0] quat_single [3];

   assign fire      = req.valid && req.ready;
   assign req.ready = !skid_valid_ff;
   assign take      = out_valid_ff && rsp.ready;
   assign tag       = req.tag_byte[7:3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         word_axes[i] = req.payload[16*i +: 16];
      end
   end

   // A frame_start word discards whatever partial frame is in progress.
   assign pos_base   = req.frame_start ? 2'd0 : pos_ff;
   assign seen_base  = req.frame_start ? imu_ffd_pkg::SEEN_NONE : seen_ff;
   assign fault_base = req.frame_start ? imu_ffd_pkg::ST_OK : fault_ff;
   assign last       = (pos_base == imu_ffd_pkg::LAST_POS);

   always_comb begin
      if (tag == gyro_tag_ff) begin
         kind = imu_ffd_pkg::SEEN_GYRO;
      end else if (tag == accel_tag_ff) begin
         kind = imu_ffd_pkg::SEEN_ACCEL;
      end else if (tag == quat_tag_ff) begin
         kind = imu_ffd_pkg::SEEN_QUAT;
      end else begin
         kind = imu_ffd_pkg::SEEN_NONE;
      end
   end

   // Once a fault is recorded the remaining words of the frame only move the position on.
   always_comb begin
      fault_new = fault_base;
      seen_new  = seen_base;
      hold_wr   = 1'b0;
      if (fault_base == imu_ffd_pkg::ST_OK) begin
         if (kind == imu_ffd_pkg::SEEN_NONE) begin
            fault_new = imu_ffd_pkg::ST_UNKNOWN;
         end else if ((seen_base & kind) != imu_ffd_pkg::SEEN_NONE) begin
            fault_new = imu_ffd_pkg::ST_DUPLICATE;
         end else begin
            seen_new = seen_base | kind;
            hold_wr  = 1'b1;
         end
      end
   end

   always_comb begin
      gyro_in  = gyro_ff;
      accel_in = accel_ff;
      quat_in  = quat_ff;
      if (fire && hold_wr) begin
         if (kind == imu_ffd_pkg::SEEN_GYRO) begin
            gyro_in = word_axes;
         end
         if (kind == imu_ffd_pkg::SEEN_ACCEL) begin
            accel_in = word_axes;
         end
         if (kind == imu_ffd_pkg::SEEN_QUAT) begin
            quat_in = word_axes;
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_widen
      imu_ffd_half_widen u_widen (
         .half_in    (quat_in[g]),
         .single_out (quat_single[g])
      );
   end

   always_comb begin
      status = fault_new;
      if (status == imu_ffd_pkg::ST_OK && seen_new != imu_ffd_pkg::SEEN_ALL) begin
         status = imu_ffd_pkg::ST_MISSING;
      end
      if (status == imu_ffd_pkg::ST_OK &&
          (quat_in[0][14:10] == imu_ffd_pkg::HALF_EXP_ONES ||
           quat_in[1][14:10] == imu_ffd_pkg::HALF_EXP_ONES ||
           quat_in[2][14:10] == imu_ffd_pkg::HALF_EXP_ONES)) begin
         status = imu_ffd_pkg::ST_INFNAN;
      end
   end

   always_comb begin
      rsp_new = '0;
      rsp_new.frame_status = status;
      if (status == imu_ffd_pkg::ST_OK) begin
         rsp_new.gyro_x      = gyro_in[0];
         rsp_new.gyro_y      = gyro_in[1];
         rsp_new.gyro_z      = gyro_in[2];
         rsp_new.accel_x     = accel_in[0];
         rsp_new.accel_y     = accel_in[1];
         rsp_new.accel_z     = accel_in[2];
         rsp_new.quat_x_bits = quat_single[0];
         rsp_new.quat_y_bits = quat_single[1];
         rsp_new.quat_z_bits = quat_single[2];
      end
   end

   assign new_rsp = fire && last;

   always_comb begin
      pos_in   = pos_ff;
      seen_in  = seen_ff;
      fault_in = fault_ff;
      if (fire) begin
         if (last) begin
            pos_in   = 2'd0;
            seen_in  = imu_ffd_pkg::SEEN_NONE;
            fault_in = imu_ffd_pkg::ST_OK;
         end else begin
            pos_in   = pos_base + 2'd1;
            seen_in  = seen_new;
            fault_in = fault_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_tag_ff  <= imu_ffd_pkg::GYRO_TAG_RESET;
         accel_tag_ff <= imu_ffd_pkg::ACCEL_TAG_RESET;
         quat_tag_ff  <= imu_ffd_pkg::QUAT_TAG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            imu_ffd_pkg::CSR_GYRO_TAG:  gyro_tag_ff  <= csr_wdata;
            imu_ffd_pkg::CSR_ACCEL_TAG: accel_tag_ff <= csr_wdata;
            imu_ffd_pkg::CSR_QUAT_TAG:  quat_tag_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         seen_ff  <= imu_ffd_pkg::SEEN_NONE;
         fault_ff <= imu_ffd_pkg::ST_OK;
      end else begin
         pos_ff   <= pos_in;
         seen_ff  <= seen_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      gyro_ff  <= gyro_in;
      accel_ff <= accel_in;
      quat_ff  <= quat_in;
   end

   // Output register with a skid stage; a request is refused only while the skid is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (new_rsp) begin
         if (!out_valid_ff || take) begin
            out_ff       <= rsp_new;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= rsp_new;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.frame_status = out_ff.frame_status;
   assign rsp.gyro_x       = out_ff.gyro_x;
   assign rsp.gyro_y       = out_ff.gyro_y;
   assign rsp.gyro_z       = out_ff.gyro_z;
   assign rsp.accel_x      = out_ff.accel_x;
   assign rsp.accel_y      = out_ff.accel_y;
   assign rsp.accel_z      = out_ff.accel_z;
   assign rsp.quat_x_bits  = out_ff.quat_x_bits;
   assign rsp.quat_y_bits  = out_ff.quat_y_bits;
   assign rsp.quat_z_bits  = out_ff.quat_z_bits;

   `IMU_FFD_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `IMU_FFD_ASSERT_IMP(a_pos_in_range, clock, reset, 1'b1, pos_ff != 2'd3)
   `IMU_FFD_ASSERT_NXT(a_frame_end_clears, clock, reset, fire && last,
      pos_ff == 2'd0 && seen_ff == imu_ffd_pkg::SEEN_NONE && fault_ff == imu_ffd_pkg::ST_OK)
   `IMU_FFD_ASSERT_IMP(a_fault_zeroes_fields, clock, reset,
      out_valid_ff && out_ff.frame_status != imu_ffd_pkg::ST_OK,
      out_ff.gyro_x == 16'sd0 && out_ff.accel_z == 16'sd0 && out_ff.quat_x_bits == 32'd0)
   `IMU_FFD_ASSERT_IMP(a_ok_is_finite, clock, reset,
      out_valid_ff && out_ff.frame_status == imu_ffd_pkg::ST_OK,
      out_ff.quat_x_bits[30:23] != 8'hff && out_ff.quat_y_bits[30:23] != 8'hff &&
      out_ff.quat_z_bits[30:23] != 8'hff)

endmodule

// ----- design/imu_ffd_half_widen.sv -----
// Widens a half-precision bit pattern to single-precision bits.
// Uses imu_ffd_pkg constants; purely combinational.
module imu_ffd_half_widen (
   input  logic [15:0] half_in,
   output logic [31:0] single_out
);

   logic [9:0]  man;
   logic [4:0]  hexp;
   logic [3:0]  msb_pos;
   logic [3:0]  shift_amt;
   logic [19:0] man_shifted;
   logic [7:0]  sub_exp;
   logic [17:0] norm_sum;

   assign man  = half_in[9:0];
   assign hexp = half_in[14:10];

   // Position of the leading one of a subnormal significand.
   always_comb begin
      msb_pos = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) begin
            msb_pos = 4'(i);
         end
      end
   end

   assign shift_amt   = imu_ffd_pkg::HALF_MAN_BITS - msb_pos;
   assign man_shifted = {10'b0, man} << shift_amt;
   assign sub_exp     = imu_ffd_pkg::SUBNORM_EXP_BASE + {4'b0, msb_pos};
   assign norm_sum    = {3'b0, half_in[14:0]} + imu_ffd_pkg::HALF_EXP_REBIAS;

   always_comb begin
      if (hexp == 5'd0) begin
         if (man == 10'd0) begin
            single_out = {half_in[15], 31'b0};
         end else begin
            single_out = {half_in[15], sub_exp, man_shifted[9:0], 13'b0};
         end
      end else begin
         single_out = {half_in[15], norm_sum, 13'b0};
      end
   end

endmodule

// ----- tb/imu_ffd_frame_checker.sv -----
// Frame checker for the IMU FIFO frame decoder: predicts a status result for every completed
// frame from the accepted requests and tag register writes, and compares it with the result channel.
// Depends on imu_ffd_pkg and the channel interfaces in imu_ffd_if.sv.
module imu_ffd_frame_checker (
   input  logic        clock,
   input  logic        reset,
   imu_ffd_req_if      req,
   imu_ffd_rsp_if      rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata,
   output int unsigned mismatches,
   output int unsigned frames_due
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [4:0]  gyro_code;
   logic [4:0]  accel_code;
   logic [4:0]  quat_code;
   logic [1:0]  word_index;
   logic [2:0]  kinds_seen;
   logic [2:0]  fault_code;
   imu_ffd_pkg::axes_type gyro_axes;
   imu_ffd_pkg::axes_type accel_axes;
   imu_ffd_pkg::axes_type quat_halves;
   imu_ffd_pkg::rsp_type  expected_frames[$];
   int unsigned reported;

   initial begin
      mismatches = 0;
      frames_due = 0;
      reported = 0;
   end

   // Half to single precision; a subnormal half is normalised around its leading one.
   function automatic logic [31:0] widen_half(input logic [15:0] half);
      logic [4:0] expo;
      logic [9:0] man;
      int         top_bit;
      expo = half[14:10];
      man = half[9:0];
      top_bit = 0;
      if (expo != 5'd0) begin
         return {half[15], 8'({3'd0, expo} + 8'd112), man, 13'd0};
      end
      if (man == 10'd0) begin
         return {half[15], 31'd0};
      end
      for (int i = 0; i < 10; i++) begin
         if (man[i]) begin
            top_bit = i;
         end
      end
      return {half[15], 8'(imu_ffd_pkg::SUBNORM_EXP_BASE + top_bit),
              10'(man << (10 - top_bit)), 13'd0};
   endfunction

   // Applies one FIFO word to the frame state; returns 1 when the word closes a frame.
   function automatic bit decode_fifo_word(input logic [7:0] tag_byte, input logic [47:0] payload,
                                           input logic frame_start,
                                           output imu_ffd_pkg::rsp_type frame);
      logic [4:0] tag;
      logic [2:0] kind;
      logic [2:0] status;
      tag = tag_byte[7:3];
      frame = '0;
      if (frame_start) begin
         word_index = 2'd0;
         kinds_seen = imu_ffd_pkg::SEEN_NONE;
         fault_code = imu_ffd_pkg::ST_OK;
      end
      // Once a frame has faulted, its remaining words only move the position on.
      if (fault_code == imu_ffd_pkg::ST_OK) begin
         if (tag == gyro_code) kind = imu_ffd_pkg::SEEN_GYRO;
         else if (tag == accel_code) kind = imu_ffd_pkg::SEEN_ACCEL;
         else if (tag == quat_code) kind = imu_ffd_pkg::SEEN_QUAT;
         else kind = imu_ffd_pkg::SEEN_NONE;
         if (kind == imu_ffd_pkg::SEEN_NONE) begin
            fault_code = imu_ffd_pkg::ST_UNKNOWN;
         end else if ((kinds_seen & kind) != imu_ffd_pkg::SEEN_NONE) begin
            fault_code = imu_ffd_pkg::ST_DUPLICATE;
         end else begin
            case (kind)
               imu_ffd_pkg::SEEN_GYRO: gyro_axes = payload;
               imu_ffd_pkg::SEEN_ACCEL: accel_axes = payload;
               default: quat_halves = payload;
            endcase
            kinds_seen = kinds_seen | kind;
         end
      end
      if (word_index != imu_ffd_pkg::LAST_POS) begin
         word_index = word_index + 2'd1;
         return 1'b0;
      end
      status = fault_code;
      if (status == imu_ffd_pkg::ST_OK && kinds_seen != imu_ffd_pkg::SEEN_ALL) begin
         status = imu_ffd_pkg::ST_MISSING;
      end
      if (status == imu_ffd_pkg::ST_OK) begin
         for (int i = 0; i < 3; i++) begin
            if (quat_halves[i][14:10] == imu_ffd_pkg::HALF_EXP_ONES) begin
               status = imu_ffd_pkg::ST_INFNAN;
            end
         end
      end
      frame.frame_status = status;
      if (status == imu_ffd_pkg::ST_OK) begin
         frame.gyro_x = gyro_axes[0];
         frame.gyro_y = gyro_axes[1];
         frame.gyro_z = gyro_axes[2];
         frame.accel_x = accel_axes[0];
         frame.accel_y = accel_axes[1];
         frame.accel_z = accel_axes[2];
         frame.quat_x_bits = widen_half(quat_halves[0]);
         frame.quat_y_bits = widen_half(quat_halves[1]);
         frame.quat_z_bits = widen_half(quat_halves[2]);
      end
      word_index = 2'd0;
      kinds_seen = imu_ffd_pkg::SEEN_NONE;
      fault_code = imu_ffd_pkg::ST_OK;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (reported < 10) begin
            reported++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
         end
      end
   endtask

   task automatic compare_result();
      imu_ffd_pkg::rsp_type want;
      if (expected_frames.size() == 0) begin
         mismatches++;
         if (reported < 10) begin
            reported++;
            $display("%0t: frame result with status %0d arrived with none pending",
                     $realtime, rsp.frame_status);
         end
         return;
      end
      want = expected_frames.pop_front();
      check_field("frame_status", want.frame_status, rsp.frame_status);
      check_field("gyro_x", want.gyro_x, rsp.gyro_x);
      check_field("gyro_y", want.gyro_y, rsp.gyro_y);
      check_field("gyro_z", want.gyro_z, rsp.gyro_z);
      check_field("accel_x", want.accel_x, rsp.accel_x);
      check_field("accel_y", want.accel_y, rsp.accel_y);
      check_field("accel_z", want.accel_z, rsp.accel_z);
      check_field("quat_x_bits", want.quat_x_bits, rsp.quat_x_bits);
      check_field("quat_y_bits", want.quat_y_bits, rsp.quat_y_bits);
      check_field("quat_z_bits", want.quat_z_bits, rsp.quat_z_bits);
   endtask

   always @(posedge clock) begin
      imu_ffd_pkg::rsp_type predicted;
      if (reset) begin
         gyro_code = imu_ffd_pkg::GYRO_TAG_RESET;
         accel_code = imu_ffd_pkg::ACCEL_TAG_RESET;
         quat_code = imu_ffd_pkg::QUAT_TAG_RESET;
         word_index = 2'd0;
         kinds_seen = imu_ffd_pkg::SEEN_NONE;
         fault_code = imu_ffd_pkg::ST_OK;
         gyro_axes = '0;
         accel_axes = '0;
         quat_halves = '0;
         expected_frames.delete();
      end else begin
         // A result taken at this edge always belongs to an earlier request.
         if (rsp.valid && rsp.ready) compare_result();
         // A request taken at this edge still sees the tag codes from before it.
         if (req.valid && req.ready) begin
            if (decode_fifo_word(req.tag_byte, req.payload, req.frame_start, predicted)) begin
               expected_frames.push_back(predicted);
            end
         end
         if (csr_we) begin
            case (csr_index)
               imu_ffd_pkg::CSR_GYRO_TAG: gyro_code = csr_wdata;
               imu_ffd_pkg::CSR_ACCEL_TAG: accel_code = csr_wdata;
               imu_ffd_pkg::CSR_QUAT_TAG: quat_code = csr_wdata;
               default: ;
            endcase
         end
      end
      frames_due = expected_frames.size();
   end

endmodule

// ----- tb/imu_fifo_frame_decoder_test.sv -----
// Top of the IMU FIFO frame decoder testbench: clock, reset, tag register settings and
// request traffic, with a randomly stalling result receiver. Checking is left to
// imu_ffd_frame_checker; needs imu_ffd_pkg, imu_ffd_if.sv and the decoder RTL.
module imu_fifo_frame_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_FRAMES = 55;

   typedef enum {KIND_GYRO, KIND_ACCEL, KIND_QUAT, KIND_STRAY} word_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [4:0]  csr_wdata;
   int unsigned mismatches;
   int unsigned frames_due;
   int unsigned cycle_count = 0;
   int unsigned results_taken;
   logic [4:0]  gyro_tag;
   logic [4:0]  accel_tag;
   logic [4:0]  quat_tag;
   bit          aligned;
   int          send_calm = 0;
   int          take_calm = 0;

   imu_ffd_req_if req_ch();
   imu_ffd_rsp_if rsp_ch();

   imu_fifo_frame_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   imu_ffd_frame_checker frame_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .frames_due (frames_due)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Mostly back to back, sometimes a few cycles, rarely a long pause; now and then a calm run.
   function automatic int gap_len(inout int calm);
      int pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Biased towards subnormals, zeros and an all-ones exponent.
   function automatic logic [15:0] random_half();
      int          pick;
      logic [15:0] half;
      pick = $urandom_range(0, 99);
      half = 16'($urandom);
      if (pick < 12) half[14:0] = {5'd0, 10'(10'($urandom) >> $urandom_range(0, 10))};
      else if (pick < 18) half[14:10] = imu_ffd_pkg::HALF_EXP_ONES;
      return half;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_word(input logic [7:0] tag_byte, input logic [47:0] payload,
                            input logic frame_start);
      int gap;
      gap = gap_len(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.tag_byte <= tag_byte;
      req_ch.payload <= payload;
      req_ch.frame_start <= frame_start;
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_kind(input word_kind_type kind, input logic frame_start);
      logic [4:0]  tag;
      logic [47:0] payload;
      payload = 48'({$urandom, $urandom});
      case (kind)
         KIND_GYRO: tag = gyro_tag;
         KIND_ACCEL: tag = accel_tag;
         KIND_QUAT: begin
            tag = quat_tag;
            payload = {random_half(), random_half(), random_half()};
         end
         default: tag = 5'($urandom);
      endcase
      send_word({tag, 3'($urandom)}, payload, frame_start);
   endtask

   // Stops offering requests and lets every expected result out, plus a few spare cycles
   // in case a partial frame is still in flight.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (frames_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_tags(input logic [4:0] gyro, input logic [4:0] accel, input logic [4:0] quat);
      drain();
      csr_we <= 1'b1;
      csr_index <= imu_ffd_pkg::CSR_GYRO_TAG;
      csr_wdata <= gyro;
      @(negedge clock);
      csr_index <= imu_ffd_pkg::CSR_ACCEL_TAG;
      csr_wdata <= accel;
      @(negedge clock);
      csr_index <= imu_ffd_pkg::CSR_QUAT_TAG;
      csr_wdata <= quat;
      @(negedge clock);
      csr_we <= 1'b0;
      gyro_tag = gyro;
      accel_tag = accel;
      quat_tag = quat;
   endtask

   // Runs with the reset tag codes.
   task automatic run_directed();
      logic [7:0] gyro_b;
      logic [7:0] accel_b;
      logic [7:0] quat_b;
      gyro_b = {imu_ffd_pkg::GYRO_TAG_RESET, 3'd7};
      accel_b = {imu_ffd_pkg::ACCEL_TAG_RESET, 3'd0};
      quat_b = {imu_ffd_pkg::QUAT_TAG_RESET, 3'd7};
      // Axis extremes; zero, smallest subnormal and negative zero halves.
      send_word(gyro_b, {16'h8000, 16'h7fff, 16'hffff}, 1'b1);
      send_word(accel_b, 48'h0, 1'b0);
      send_word(quat_b, {16'h8000, 16'h0001, 16'h0000}, 1'b0);
      // Quaternion first; one, a subnormal and the largest negative subnormal.
      send_word(quat_b, {16'h3c00, 16'h0200, 16'h83ff}, 1'b1);
      send_word(gyro_b, 48'hffff_ffff_ffff, 1'b0);
      send_word(accel_b, {16'h0000, 16'h8000, 16'h7fff}, 1'b0);
      // Largest finite halves and the smallest normal one.
      send_word(quat_b, {16'h0400, 16'hfbff, 16'h7bff}, 1'b0);
      send_word(accel_b, 48'h1234_5678_9abc, 1'b0);
      send_word(gyro_b, 48'hfedc_ba98_7654, 1'b0);
      // Infinity, then a NaN, in otherwise complete frames.
      send_word(gyro_b, 48'h0001_0002_0003, 1'b1);
      send_word(accel_b, 48'h0004_0005_0006, 1'b0);
      send_word(quat_b, {16'h0000, 16'h0000, 16'h7c00}, 1'b0);
      send_word(gyro_b, 48'h0, 1'b0);
      send_word(quat_b, {16'hfe01, 16'h3c00, 16'h3c00}, 1'b0);
      send_word(accel_b, 48'h0, 1'b0);
      // Unknown tag; the words after it, an infinity among them, are ignored.
      send_word(8'hff, 48'h0, 1'b1);
      send_word(8'h00, 48'h0, 1'b0);
      send_word(quat_b, {16'h7c00, 16'h7c00, 16'h7c00}, 1'b0);
      // Duplicate tag.
      send_word(gyro_b, 48'h1, 1'b0);
      send_word({imu_ffd_pkg::GYRO_TAG_RESET, 3'd0}, 48'h2, 1'b0);
      send_word(accel_b, 48'h3, 1'b0);
      // A partial frame dropped by a restart in the middle.
      send_word(gyro_b, 48'h5555_5555_5555, 1'b0);
      send_word(accel_b, 48'haaaa_aaaa_aaaa, 1'b0);
      send_word(accel_b, 48'h0102_0304_0506, 1'b1);
      send_word(quat_b, {16'hbc00, 16'h4000, 16'h0155}, 1'b0);
      send_word(gyro_b, 48'h0708_090a_0b0c, 1'b0);
      aligned = 1'b1;
   endtask

   task automatic run_random(input int frames);
      word_kind_type order[3];
      word_kind_type swap;
      int            pick;
      int            words;
      int            j;
      for (int f = 0; f < frames; f++) begin
         pick = $urandom_range(0, 99);
         order[0] = KIND_GYRO;
         order[1] = KIND_ACCEL;
         order[2] = KIND_QUAT;
         for (int i = 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
         end
         if (pick < 75) begin
            for (int i = 0; i < 3; i++) begin
               send_kind(order[i], (i == 0) && (!aligned || $urandom_range(0, 1) == 1));
            end
            aligned = 1'b1;
         end else if (pick < 90) begin
            for (int i = 0; i < 3; i++) begin
               send_kind(word_kind_type'($urandom_range(0, 3)),
                         (i == 0) && (!aligned || $urandom_range(0, 1) == 1));
            end
            aligned = 1'b1;
         end else begin
            words = $urandom_range(1, 2);
            for (int i = 0; i < words; i++) begin
               send_kind(order[i], 1'($urandom_range(0, 1)));
            end
            aligned = 1'b0;
         end
      end
   endtask

   // Result receiver; twice it holds off long enough for the decoder to back up.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      results_taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_taken == 30 || results_taken == 250) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         gap = gap_len(take_calm);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         results_taken++;
         @(negedge clock);
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.tag_byte = 8'h00;
      req_ch.payload = 48'h0;
      req_ch.frame_start = 1'b0;
      csr_we = 1'b0;
      csr_index = imu_ffd_pkg::CSR_GYRO_TAG;
      csr_wdata = 5'd0;
      gyro_tag = imu_ffd_pkg::GYRO_TAG_RESET;
      accel_tag = imu_ffd_pkg::ACCEL_TAG_RESET;
      quat_tag = imu_ffd_pkg::QUAT_TAG_RESET;
      aligned = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(RANDOM_FRAMES);
      set_tags(5'd0, 5'd31, 5'd16);
      run_random(RANDOM_FRAMES);
      set_tags(5'd31, 5'd0, 5'd7);
      run_random(RANDOM_FRAMES);
      // Equal codes: gyro wins over accel, so accel words turn into duplicates.
      set_tags(5'd5, 5'd5, 5'd9);
      run_random(RANDOM_FRAMES);
      set_tags(5'd12, 5'd12, 5'd12);
      run_random(RANDOM_FRAMES);
      set_tags(5'($urandom), 5'($urandom), 5'($urandom));
      run_random(RANDOM_FRAMES);
      drain();
      repeat (16) @(negedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
